@@ src/lpcs_pkg.sv @@
// Package for the lidar point curvature stencil.
// Holds default sizes, fixed result widths and the result tag type.
// No dependencies.
package lpcs_pkg;

  localparam int HALF_WINDOW_DEF      = 5;
  localparam int MAX_FRAME_POINTS_DEF = 262144;
  localparam int COORD_BITS_DEF       = 20;

  localparam int CURV_W = 49;
  localparam int IDX_W  = 18;
  localparam int AXES   = 3;

  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] idx;
  } lpcs_tag_t;

endpackage

@@ src/lpcs_in_if.sv @@
// Point request channel: valid/ready handshake with one lidar point.
// Depends on lpcs_pkg for the default coordinate width.
interface lpcs_in_if #(
  parameter int COORD_BITS = lpcs_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_mm;
  logic [COORD_BITS-1:0] y_mm;
  logic [COORD_BITS-1:0] z_mm;
  logic                  frame_end;

  modport source (output valid, output x_mm, output y_mm, output z_mm,
                  output frame_end, input ready);
  modport sink   (input valid, input x_mm, input y_mm, input z_mm,
                  input frame_end, output ready);
endinterface

@@ src/lpcs_out_if.sv @@
// Curvature result channel: valid/ready handshake with one result request.
// Depends on lpcs_pkg for the result widths.
interface lpcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpcs_pkg::CURV_W-1:0] curvature;
  logic [lpcs_pkg::IDX_W-1:0]  center_index;
  logic                        frame_end_out;

  modport source (output valid, output curvature, output center_index,
                  output frame_end_out, input ready);
  modport sink   (input valid, input curvature, input center_index,
                  input frame_end_out, output ready);
endinterface

@@ src/lidar_point_curvature_stencil_top.sv @@
// Lidar point curvature stencil, top level.
// Throughput: one point per cycle while out_ready holds; a held result backs up
// through all four registered stages, and input ready follows out_ready in the same
// cycle once they are full.
// Reset (synchronous, rst_n low): clears frame count, running sums and stage valids;
// the point window is not cleared, it is only read once the frame has refilled it.
module lidar_point_curvature_stencil_top #(
  parameter int HALF_WINDOW      = lpcs_pkg::HALF_WINDOW_DEF,
  parameter int MAX_FRAME_POINTS = lpcs_pkg::MAX_FRAME_POINTS_DEF,
  parameter int COORD_BITS       = lpcs_pkg::COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lpcs_in_if.sink    in_ch,
  lpcs_out_if.source out_ch
);
  import lpcs_pkg::*;

  localparam int SUMW = COORD_BITS + $clog2(2 * HALF_WINDOW);

  logic [AXES-1:0][COORD_BITS-1:0] in_pt;
  logic                            in_ready;
  logic                            a_valid;
  logic                            a_ready;
  logic [AXES-1:0][COORD_BITS-1:0] a_pt;
  logic [AXES-1:0][SUMW-1:0]       a_sum;
  logic [AXES-1:0][COORD_BITS-1:0] a_ctr;
  lpcs_tag_t                       a_tag;
  logic                            out_valid;
  logic [CURV_W-1:0]               out_curv;
  lpcs_tag_t                       out_tag;

  assign in_pt[0]    = in_ch.x_mm;
  assign in_pt[1]    = in_ch.y_mm;
  assign in_pt[2]    = in_ch.z_mm;
  assign in_ch.ready = in_ready;

  lpcs_front #(
    .HALF_WINDOW      (HALF_WINDOW),
    .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
    .COORD_BITS       (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_pt    (in_pt),
    .in_last  (in_ch.frame_end),
    .a_valid  (a_valid),
    .a_ready  (a_ready),
    .a_pt     (a_pt),
    .a_sum    (a_sum),
    .a_ctr    (a_ctr),
    .a_tag    (a_tag)
  );

  lpcs_back #(
    .HALF_WINDOW (HALF_WINDOW),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_pt      (a_pt),
    .a_sum     (a_sum),
    .a_ctr     (a_ctr),
    .a_tag     (a_tag),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_curv  (out_curv),
    .out_tag   (out_tag)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.curvature     = out_curv;
  assign out_ch.center_index  = out_tag.idx;
  assign out_ch.frame_end_out = out_tag.last;

endmodule

@@ src/lpcs_front.sv @@
// Point window, running window sum and frame point counter.
// Registers the center, running window sum and new point of each full window.
// Depends on lpcs_pkg.
module lpcs_front #(
  parameter int HALF_WINDOW      = lpcs_pkg::HALF_WINDOW_DEF,
  parameter int MAX_FRAME_POINTS = lpcs_pkg::MAX_FRAME_POINTS_DEF,
  parameter int COORD_BITS       = lpcs_pkg::COORD_BITS_DEF
) (
  input  logic                                                        clk,
  input  logic                                                        rst_n,
  input  logic                                                        in_valid,
  output logic                                                        in_ready,
  input  logic [lpcs_pkg::AXES-1:0][COORD_BITS-1:0]                   in_pt,
  input  logic                                                        in_last,
  output logic                                                        a_valid,
  input  logic                                                        a_ready,
  output logic [lpcs_pkg::AXES-1:0][COORD_BITS-1:0]                   a_pt,
  output logic [lpcs_pkg::AXES-1:0][COORD_BITS+$clog2(2*HALF_WINDOW)-1:0] a_sum,
  output logic [lpcs_pkg::AXES-1:0][COORD_BITS-1:0]                   a_ctr,
  output lpcs_pkg::lpcs_tag_t                                         a_tag
);
  import lpcs_pkg::*;

  localparam int WIN   = 2 * HALF_WINDOW;
  localparam int SUMW  = COORD_BITS + $clog2(2 * HALF_WINDOW);
  localparam int CNT_W = $clog2(MAX_FRAME_POINTS);
  localparam int IXW   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [AXES-1:0][COORD_BITS-1:0] win_r [WIN];
  logic [AXES-1:0][SUMW-1:0]       sum_r;
  logic [AXES-1:0][SUMW-1:0]       sum_nxt;
  logic [CNT_W-1:0]                cnt_r;
  logic [CNT_W-1:0]                cnt_nxt;
  logic                            full;
  logic                            accept;
  logic [IXW-1:0]                  idx_wide;
  logic                            a_valid_r;
  logic [AXES-1:0][COORD_BITS-1:0] a_pt_r;
  logic [AXES-1:0][SUMW-1:0]       a_sum_r;
  logic [AXES-1:0][COORD_BITS-1:0] a_ctr_r;
  lpcs_tag_t                       a_tag_r;

  assign full     = (cnt_r >= CNT_W'(WIN));
  assign in_ready = !a_valid_r || a_ready;
  assign accept   = in_valid && in_ready;
  assign idx_wide = IXW'(cnt_r) - IXW'(HALF_WINDOW);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_nxt[a] = sum_r[a] + {{(SUMW-COORD_BITS){in_pt[a][COORD_BITS-1]}}, in_pt[a]}
                 - (full ? {{(SUMW-COORD_BITS){win_r[0][a][COORD_BITS-1]}}, win_r[0][a]}
                         : SUMW'(0));
    end
    if (cnt_r < CNT_W'(MAX_FRAME_POINTS - 1)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
    if (in_last) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // advance the window; stale entries are never read before the frame refills it
  always_ff @(posedge clk) begin
    if (accept && !in_last) begin
      for (int k = 0; k < WIN - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WIN-1] <= in_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= accept && full;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && full) begin
      a_pt_r       <= in_pt;
      a_sum_r      <= sum_r;
      a_ctr_r      <= win_r[HALF_WINDOW];
      a_tag_r.idx  <= idx_wide[IDX_W-1:0];
      a_tag_r.last <= in_last;
    end
  end

  assign a_valid = a_valid_r;
  assign a_pt    = a_pt_r;
  assign a_sum   = a_sum_r;
  assign a_ctr   = a_ctr_r;
  assign a_tag   = a_tag_r;

endmodule

@@ src/lpcs_back.sv @@
// Stencil arithmetic: per-axis difference, squares, then their sum.
// Three registered stages with per-stage flow control; depends on lpcs_pkg.
module lpcs_back #(
  parameter int HALF_WINDOW = lpcs_pkg::HALF_WINDOW_DEF,
  parameter int COORD_BITS  = lpcs_pkg::COORD_BITS_DEF
) (
  input  logic                                                        clk,
  input  logic                                                        rst_n,
  input  logic                                                        a_valid,
  output logic                                                        a_ready,
  input  logic [lpcs_pkg::AXES-1:0][COORD_BITS-1:0]                   a_pt,
  input  logic [lpcs_pkg::AXES-1:0][COORD_BITS+$clog2(2*HALF_WINDOW)-1:0] a_sum,
  input  logic [lpcs_pkg::AXES-1:0][COORD_BITS-1:0]                   a_ctr,
  input  lpcs_pkg::lpcs_tag_t                                         a_tag,
  output logic                                                        out_valid,
  input  logic                                                        out_ready,
  output logic [lpcs_pkg::CURV_W-1:0]                                 out_curv,
  output lpcs_pkg::lpcs_tag_t                                         out_tag
);
  import lpcs_pkg::*;

  localparam int SUMW = COORD_BITS + $clog2(2 * HALF_WINDOW);
  localparam int DW   = COORD_BITS + $clog2(4 * HALF_WINDOW);
  localparam int SQW  = 2 * DW;
  localparam int SW   = (SQW + 2 > CURV_W) ? SQW + 2 : CURV_W;

  logic                     b_adv;
  logic                     c_adv;
  logic                     o_adv;
  logic [AXES-1:0][DW-1:0]  d_nxt;
  logic signed [SQW-1:0]    sq_nxt [AXES];
  logic [SW-1:0]            total;

  logic                     b_valid_r;
  logic [AXES-1:0][DW-1:0]  b_d_r;
  lpcs_tag_t                b_tag_r;
  logic                     c_valid_r;
  logic [AXES-1:0][SQW-1:0] c_sq_r;
  lpcs_tag_t                c_tag_r;
  logic                     o_valid_r;
  logic [CURV_W-1:0]        o_curv_r;
  lpcs_tag_t                o_tag_r;

  assign o_adv   = !o_valid_r || out_ready;
  assign c_adv   = !c_valid_r || o_adv;
  assign b_adv   = !b_valid_r || c_adv;
  assign a_ready = b_adv;

  // neighbors plus new point minus (2H+1) times center, since the sum holds the center
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d_nxt[a] = {{(DW-COORD_BITS){a_pt[a][COORD_BITS-1]}}, a_pt[a]}
               + {{(DW-SUMW){a_sum[a][SUMW-1]}}, a_sum[a]}
               - {{(DW-COORD_BITS){a_ctr[a][COORD_BITS-1]}}, a_ctr[a]}
                 * DW'(2 * HALF_WINDOW + 1);
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sq_nxt[a] = $signed(b_d_r[a]) * $signed(b_d_r[a]);
    end
  end

  assign total = SW'(c_sq_r[0]) + SW'(c_sq_r[1]) + SW'(c_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (b_adv) begin
        b_valid_r <= a_valid;
      end
      if (c_adv) begin
        c_valid_r <= b_valid_r;
      end
      if (o_adv) begin
        o_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_d_r   <= d_nxt;
      b_tag_r <= a_tag;
    end
    if (c_adv && b_valid_r) begin
      for (int a = 0; a < AXES; a++) begin
        c_sq_r[a] <= SQW'(unsigned'(sq_nxt[a]));
      end
      c_tag_r <= b_tag_r;
    end
    if (o_adv && c_valid_r) begin
      o_curv_r <= total[CURV_W-1:0];
      o_tag_r  <= c_tag_r;
    end
  end

  assign out_valid = o_valid_r;
  assign out_curv  = o_curv_r;
  assign out_tag   = o_tag_r;

endmodule
